FILE: rtl/lnst_pkg.sv
// ----------------------------------------------------------------------------
// lnst_pkg
// Shared widths, operation and status codes, register indexes and the slot
// record of the lane neighbor search table.
// ----------------------------------------------------------------------------
package lnst_pkg;

    localparam int unsigned TABLE_SLOTS_DEF = 16;

    localparam int unsigned OP_W       = 3;
    localparam int unsigned ID_W       = 8;
    localparam int unsigned LANE_W     = 3;
    localparam int unsigned POS_W      = 24;
    localparam int unsigned LAT_W      = 12;
    localparam int unsigned SPD_W      = 16;
    localparam int unsigned STAT_W     = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned WRAP_W     = 27;
    localparam int unsigned LANE_SHIFT = 10;

    localparam logic [OP_W-1:0] OP_UPD_VEH = 3'd0;
    localparam logic [OP_W-1:0] OP_UPD_EGO = 3'd1;
    localparam logic [OP_W-1:0] OP_AHEAD   = 3'd2;
    localparam logic [OP_W-1:0] OP_BEHIND  = 3'd3;
    localparam logic [OP_W-1:0] OP_ADJ     = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_LANE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LANE  = 1'd1;

    localparam logic [POS_W-1:0]  TRACK_LEN_RST = 24'd1778062;
    localparam logic [LANE_W-1:0] MAX_LANE_RST  = 3'd2;
    localparam logic [LAT_W-1:0]  LAT_LIMIT     = 12'd512;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LANE_W-1:0] lane;
        logic [POS_W-1:0]  pos;
        logic [LAT_W-1:0]  lat;
        logic [SPD_W-1:0]  speed;
    } t_slot;

    function automatic logic signed [WRAP_W-1:0] to_wrap(input logic [POS_W-1:0] v);
        return $signed({{(WRAP_W - POS_W){1'b0}}, v});
    endfunction

endpackage

FILE: rtl/lnst_req_if.sv
// ----------------------------------------------------------------------------
// lnst_req_if
// Request channel: one operation with its vehicle data and search window.
// ----------------------------------------------------------------------------
interface lnst_req_if
    import lnst_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [ID_W-1:0]     vehicle_id;
    logic [LANE_W-1:0]   lane;
    logic [POS_W-1:0]    position_s;
    logic [LAT_W-1:0]    lateral_d;
    logic [SPD_W-1:0]    speed;
    logic [POS_W-1:0]    scan_window;
    logic                check_left;

    modport source (
        output valid, operation, vehicle_id, lane, position_s, lateral_d, speed,
               scan_window, check_left,
        input  ready
    );
    modport sink (
        input  valid, operation, vehicle_id, lane, position_s, lateral_d, speed,
               scan_window, check_left,
        output ready
    );
endinterface

FILE: rtl/lnst_rsp_if.sv
// ----------------------------------------------------------------------------
// lnst_rsp_if
// Response channel: search result or update status.
// ----------------------------------------------------------------------------
interface lnst_rsp_if
    import lnst_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                found;
    logic [ID_W-1:0]     found_id;
    logic [LANE_W-1:0]   found_lane;
    logic [POS_W-1:0]    found_s;
    logic [LAT_W-1:0]    found_d;
    logic [SPD_W-1:0]    found_speed;
    logic [STAT_W-1:0]   status;

    modport source (
        output valid, found, found_id, found_lane, found_s, found_d, found_speed,
               status,
        input  ready
    );
    modport sink (
        input  valid, found, found_id, found_lane, found_s, found_d, found_speed,
               status,
        output ready
    );
endinterface

FILE: rtl/lnst_slot_table.sv
// ----------------------------------------------------------------------------
// lnst_slot_table
// Vehicle slot memory with one registered read port and one write port,
// plus a valid bit per slot cleared by reset.
// ----------------------------------------------------------------------------
module lnst_slot_table
    import lnst_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [$clog2(TABLE_SLOTS)-1:0] i_rd_addr,
    output t_slot                          o_rd_ent,
    output logic                           o_rd_vbit,
    input  logic                           i_wr_en,
    input  logic [$clog2(TABLE_SLOTS)-1:0] i_wr_addr,
    input  t_slot                          i_wr_ent
);

    t_slot                  r_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_valid;
    t_slot                  r_rd_ent;
    logic                   r_rd_vbit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_ent;
        end
        if (i_rd_en) begin
            r_rd_ent  <= r_mem[i_rd_addr];
            r_rd_vbit <= r_valid[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_ent  = r_rd_ent;
    assign o_rd_vbit = r_rd_vbit;

endmodule

FILE: rtl/lane_neighbor_search_table.sv
// ----------------------------------------------------------------------------
// lane_neighbor_search_table
// Table of tracked vehicles with nearest-neighbor lane searches on a
// circular track.
// Usage:
//   i_req carries one request per valid/ready handshake: update a vehicle,
//   update the ego vehicle, search ahead or behind in a lane, or search ahead
//   in the lane left or right of the ego vehicle. o_rsp returns exactly one
//   response per request, in order, held in an output register.
//   The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) writes
//   track_length (index 0) or max_lane (index 1); write only while idle.
//   Vehicle updates and searches walk every slot of the table memory once,
//   one read per cycle, through a two-stage compare pipeline. The block is
//   ready for a new request in the same cycle as the response turns valid
//   in the output register. Ego updates, unused codes and bad adjacent
//   lanes skip the scan.
//   One request is in flight at a time; the next may be accepted while the
//   previous response still waits. A stalled receiver holds the response and
//   stops the block only once the next response is ready to be written.
//   Reset empties the table, zeroes the ego position and restores the
//   register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lane_neighbor_search_table
    import lnst_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lnst_req_if.sink              i_req,
    lnst_rsp_if.source            o_rsp
);

    localparam int unsigned IW = $clog2(TABLE_SLOTS);
    localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_SLOTS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]  r_state;
    logic [1:0]  n_state;

    logic [POS_W-1:0]  r_track_len;
    logic [LANE_W-1:0] r_max_lane;
    logic [POS_W-1:0]  r_ego_pos;
    logic [LAT_W-1:0]  r_ego_lat;

    logic [OP_W-1:0]   r_op;
    logic [ID_W-1:0]   r_id;
    logic [LANE_W-1:0] r_lane;
    logic [POS_W-1:0]  r_pos;
    logic [LAT_W-1:0]  r_lat;
    logic [SPD_W-1:0]  r_spd;
    logic [POS_W-1:0]  r_dist;
    logic              r_left;

    logic                     r_ahead;
    logic                     r_wrap;
    logic signed [WRAP_W-1:0] r_thr;
    logic signed [WRAP_W-1:0] r_bound;
    logic [LANE_W-1:0]        r_srch_lane;
    logic [STAT_W-1:0]        r_status;

    logic [CW-1:0]            r_cnt;
    logic                     r_rd_vld;
    logic [IW-1:0]            r_rd_idx;
    logic                     r_a_vld;
    logic [IW-1:0]            r_a_idx;
    logic                     r_a_hit;
    logic                     r_a_free;
    logic signed [WRAP_W-1:0] r_a_s;
    t_slot                    r_a_ent;

    logic                     r_best_vld;
    logic signed [WRAP_W-1:0] r_best_s;
    t_slot                    r_best_ent;
    logic                     r_match_vld;
    logic [IW-1:0]            r_match_idx;
    logic                     r_free_vld;
    logic [IW-1:0]            r_free_idx;

    logic              r_o_valid;
    logic              r_o_found;
    t_slot             r_o_ent;
    logic [STAT_W-1:0] r_o_status;

    logic signed [WRAP_W-1:0] e_x;
    logic signed [WRAP_W-1:0] t_x;
    logic signed [WRAP_W-1:0] d_x;
    logic signed [WRAP_W-1:0] sum_ed;
    logic                     ahead_su;
    logic                     wrap_su;
    logic signed [WRAP_W-1:0] thr_su;
    logic signed [WRAP_W-1:0] bound_su;
    logic [LANE_W-1:0]        lane_base;
    logic [LANE_W-1:0]        adj_lane;
    logic                     adj_bad;

    logic                     is_upd;
    logic                     rd_en;
    logic                     scan_done;
    t_slot                    rd_ent;
    logic                     rd_vbit;
    logic signed [WRAP_W-1:0] s_x;
    logic signed [WRAP_W-1:0] s_alt;
    logic                     s_move;
    logic signed [WRAP_W-1:0] s_adj;
    logic                     in_win;
    logic                     a_hit;
    logic                     better;

    logic                     wr_en;
    logic [IW-1:0]            wr_addr;
    t_slot                    wr_ent;

    logic                     out_free;
    logic [LAT_W-1:0]         lat_diff;
    logic                     lat_ok;
    logic                     srch_op;
    logic                     found_d;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_len <= TRACK_LEN_RST;
            r_max_lane  <= MAX_LANE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRACK_LEN: r_track_len <= i_cfg_data[POS_W-1:0];
                CFG_MAX_LANE:  r_max_lane  <= i_cfg_data[LANE_W-1:0];
                default: ;
            endcase
        end
    end

    // ----------------------------------------------------------------- setup
    assign e_x      = to_wrap(r_ego_pos);
    assign t_x      = to_wrap(r_track_len);
    assign d_x      = to_wrap(r_dist);
    assign sum_ed   = e_x + d_x;
    assign ahead_su = (r_op != OP_BEHIND);
    assign wrap_su  = ahead_su ? (sum_ed > t_x) : (e_x < d_x);
    assign thr_su   = ahead_su ? (sum_ed - t_x) : (t_x + e_x - d_x);
    assign bound_su = ahead_su ? sum_ed : (e_x - d_x);

    assign lane_base = LANE_W'(r_ego_lat >> LANE_SHIFT);
    assign adj_lane  = r_left ? (lane_base - LANE_W'(1)) : (lane_base + LANE_W'(1));
    assign adj_bad   = (r_left && (lane_base == '0)) || (adj_lane > r_max_lane);

    // ------------------------------------------------------------------ scan
    assign is_upd    = (r_op == OP_UPD_VEH);
    assign rd_en     = (r_state == S_SCAN) && (r_cnt < LAST_CNT);
    assign scan_done = (r_state == S_SCAN) && !rd_en && !r_rd_vld && !r_a_vld;

    lnst_slot_table #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_slot_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_cnt[IW-1:0]),
        .o_rd_ent  (rd_ent),
        .o_rd_vbit (rd_vbit),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_ent  (wr_ent)
    );

    assign s_x    = to_wrap(rd_ent.pos);
    assign s_alt  = r_ahead ? (s_x + t_x) : (s_x - t_x);
    assign s_move = r_wrap && (r_ahead ? (s_x < r_thr) : (s_x > r_thr));
    assign s_adj  = s_move ? s_alt : s_x;
    assign in_win = r_ahead ? ((s_adj > e_x) && (s_adj < r_bound))
                            : ((s_adj < e_x) && (s_adj > r_bound));
    assign a_hit  = is_upd ? (rd_vbit && (rd_ent.id == r_id))
                           : (rd_vbit && (rd_ent.lane == r_srch_lane) && in_win);

    assign better = !r_best_vld
                 || (r_ahead ? (r_a_s < r_best_s) : (r_a_s > r_best_s))
                 || ((r_a_s == r_best_s) && (r_a_ent.id < r_best_ent.id));

    assign wr_en   = scan_done && is_upd && (r_match_vld || r_free_vld);
    assign wr_addr = r_match_vld ? r_match_idx : r_free_idx;
    assign wr_ent  = '{id: r_id, lane: r_lane, pos: r_pos, lat: r_lat, speed: r_spd};

    // ---------------------------------------------------------------- result
    assign out_free = !r_o_valid || o_rsp.ready;
    assign lat_diff = (r_ego_lat >= r_best_ent.lat) ? (r_ego_lat - r_best_ent.lat)
                                                    : (r_best_ent.lat - r_ego_lat);
    assign lat_ok   = (lat_diff <= LAT_LIMIT);
    assign srch_op  = (r_op == OP_AHEAD) || (r_op == OP_BEHIND) || (r_op == OP_ADJ);
    assign found_d  = srch_op && r_best_vld && ((r_op != OP_ADJ) || lat_ok);

    // ----------------------------------------------------------------- state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                case (r_op)
                    OP_UPD_VEH, OP_AHEAD, OP_BEHIND: n_state = S_SCAN;
                    OP_ADJ:  n_state = adj_bad ? S_DONE : S_SCAN;
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_a_vld     <= 1'b0;
            r_best_vld  <= 1'b0;
            r_match_vld <= 1'b0;
            r_free_vld  <= 1'b0;
            r_o_valid   <= 1'b0;
            r_ego_pos   <= '0;
            r_ego_lat   <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            r_a_vld  <= r_rd_vld;
            if (r_state == S_SETUP) begin
                r_cnt       <= '0;
                r_best_vld  <= 1'b0;
                r_match_vld <= 1'b0;
                r_free_vld  <= 1'b0;
                if (r_op == OP_UPD_EGO) begin
                    r_ego_pos <= r_pos;
                    r_ego_lat <= r_lat;
                end
            end else begin
                if (rd_en) begin
                    r_cnt <= r_cnt + CW'(1);
                end
                if (r_a_vld && !is_upd && r_a_hit && better) begin
                    r_best_vld <= 1'b1;
                end
                if (r_a_vld && is_upd && r_a_hit) begin
                    r_match_vld <= 1'b1;
                end
                if (r_a_vld && is_upd && r_a_free) begin
                    r_free_vld <= 1'b1;
                end
            end
            if ((r_state == S_DONE) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // -------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_req.valid) begin
            r_op   <= i_req.operation;
            r_id   <= i_req.vehicle_id;
            r_lane <= i_req.lane;
            r_pos  <= i_req.position_s;
            r_lat  <= i_req.lateral_d;
            r_spd  <= i_req.speed;
            r_dist <= i_req.scan_window;
            r_left <= i_req.check_left;
        end
        if (r_state == S_SETUP) begin
            r_ahead     <= ahead_su;
            r_wrap      <= wrap_su;
            r_thr       <= thr_su;
            r_bound     <= bound_su;
            r_srch_lane <= (r_op == OP_ADJ) ? adj_lane : r_lane;
            r_status    <= ((r_op == OP_ADJ) && adj_bad) ? ST_BAD_LANE : ST_OK;
        end
        if (scan_done && is_upd && !r_match_vld && !r_free_vld) begin
            r_status <= ST_FULL;
        end

        r_rd_idx <= r_cnt[IW-1:0];
        r_a_idx  <= r_rd_idx;
        r_a_hit  <= a_hit;
        r_a_free <= !rd_vbit;
        r_a_s    <= s_adj;
        r_a_ent  <= rd_ent;

        if (r_a_vld && !is_upd && r_a_hit && better) begin
            r_best_s   <= r_a_s;
            r_best_ent <= r_a_ent;
        end
        if (r_a_vld && is_upd && r_a_hit && !r_match_vld) begin
            r_match_idx <= r_a_idx;
        end
        if (r_a_vld && is_upd && r_a_free && !r_free_vld) begin
            r_free_idx <= r_a_idx;
        end

        if ((r_state == S_DONE) && out_free) begin
            r_o_found  <= found_d;
            r_o_ent    <= found_d ? r_best_ent : '0;
            r_o_status <= r_status;
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.found       = r_o_found;
    assign o_rsp.found_id    = r_o_ent.id;
    assign o_rsp.found_lane  = r_o_ent.lane;
    assign o_rsp.found_s     = r_o_ent.pos;
    assign o_rsp.found_d     = r_o_ent.lat;
    assign o_rsp.found_speed = r_o_ent.speed;
    assign o_rsp.status      = r_o_status;

endmodule

FILE: rtl/lnst_checker.sv
// ----------------------------------------------------------------------------
// lnst_checker
// Port-level checks of the lane neighbor search table, bound to the top level.
// ----------------------------------------------------------------------------
module lnst_checker
    import lnst_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic              i_found,
    input logic [ID_W-1:0]   i_found_id,
    input logic [LANE_W-1:0] i_found_lane,
    input logic [POS_W-1:0]  i_found_s,
    input logic [LAT_W-1:0]  i_found_d,
    input logic [SPD_W-1:0]  i_found_speed,
    input logic [STAT_W-1:0] i_status
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid
            && $stable({i_found, i_found_id, i_found_lane, i_found_s, i_found_d,
                        i_found_speed, i_status}))
        else $error("response changed while stalled");

    a_empty_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_found |-> (i_found_id == '0) && (i_found_lane == '0)
            && (i_found_s == '0) && (i_found_d == '0) && (i_found_speed == '0))
        else $error("miss response carries vehicle data");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_found |-> (i_status == ST_OK))
        else $error("hit reported with error status");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request taken while busy");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

endmodule

bind lane_neighbor_search_table lnst_checker u_lnst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_found       (o_rsp.found),
    .i_found_id    (o_rsp.found_id),
    .i_found_lane  (o_rsp.found_lane),
    .i_found_s     (o_rsp.found_s),
    .i_found_d     (o_rsp.found_d),
    .i_found_speed (o_rsp.found_speed),
    .i_status      (o_rsp.status)
);

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lane neighbor search table. Requests are sent
// through the request channel, and each one is run through a model of the
// vehicle table kept here. Every response is compared field by field with
// the oldest predicted response. Directed checks come first, then random
// traffic under several track and lane settings and several idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import lnst_pkg::*;

    localparam int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF;
    localparam int unsigned ID_POOL     = 20;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned PHASES      = 6;
    localparam logic [OP_W-1:0] OP_LAST = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   vehicle_id;
        logic [LANE_W-1:0] lane;
        logic [POS_W-1:0]  position_s;
        logic [LAT_W-1:0]  lateral_d;
        logic [SPD_W-1:0]  speed;
        logic [POS_W-1:0]  scan_window;
        logic              check_left;
    } t_vehicle_request;

    typedef struct packed {
        logic              found;
        logic [ID_W-1:0]   id;
        logic [LANE_W-1:0] lane;
        logic [POS_W-1:0]  pos;
        logic [LAT_W-1:0]  lat;
        logic [SPD_W-1:0]  speed;
        logic [STAT_W-1:0] status;
    } t_search_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    lnst_req_if req();
    lnst_rsp_if rsp();

    lane_neighbor_search_table #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req),
        .o_rsp      (rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // table model
    t_slot             slots [TABLE_SLOTS];
    bit                slot_used [TABLE_SLOTS];
    logic [POS_W-1:0]  ego_pos;
    logic [LAT_W-1:0]  ego_lat;
    logic [POS_W-1:0]  track_len;
    logic [LANE_W-1:0] lane_limit;

    t_search_result    expected_results [$];
    logic [ID_W-1:0]   id_pool [ID_POOL];
    int unsigned       tx_idle_pct;
    int unsigned       rx_idle_pct;
    int unsigned       error_count;
    int unsigned       stalled_cycles;

    function automatic int nearest_slot(input logic [LANE_W-1:0] want_lane,
                                        input longint span, input bit ahead);
        longint t;
        longint e;
        longint s;
        longint best_s;
        int     best;
        bit     ok;
        t = track_len;
        e = ego_pos;
        best = -1;
        best_s = 0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_used[i] && slots[i].lane == want_lane) begin
                s = slots[i].pos;
                if (ahead) begin
                    if (e > t - span && s < e + span - t)
                        s += t;
                    ok = (s > e) && (s - e < span);
                end else begin
                    if (e < span && s > t + e - span)
                        s -= t;
                    ok = (s < e) && (e - s < span);
                end
                if (ok && (best < 0 || (ahead ? s < best_s : s > best_s) ||
                           (s == best_s && slots[i].id < slots[best].id))) begin
                    best = i;
                    best_s = s;
                end
            end
        end
        return best;
    endfunction

    function automatic t_search_result predict_response(input t_vehicle_request r);
        t_search_result res;
        int             k;
        int             adj;
        int             diff;
        res = '0;
        k = -1;
        case (r.op)
            OP_UPD_VEH: begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                    if (k < 0 && slot_used[i] && slots[i].id == r.vehicle_id)
                        k = i;
                for (int i = 0; i < TABLE_SLOTS; i++)
                    if (k < 0 && !slot_used[i])
                        k = i;
                if (k < 0) begin
                    res.status = ST_FULL;
                end else begin
                    slot_used[k]   = 1'b1;
                    slots[k].id    = r.vehicle_id;
                    slots[k].lane  = r.lane;
                    slots[k].pos   = r.position_s;
                    slots[k].lat   = r.lateral_d;
                    slots[k].speed = r.speed;
                end
                k = -1;
            end
            OP_UPD_EGO: begin
                ego_pos = r.position_s;
                ego_lat = r.lateral_d;
            end
            OP_AHEAD, OP_BEHIND: begin
                k = nearest_slot(r.lane, longint'(r.scan_window), r.op == OP_AHEAD);
            end
            OP_ADJ: begin
                adj = int'(ego_lat >> LANE_SHIFT);
                adj = r.check_left ? adj - 1 : adj + 1;
                if (adj < 0 || adj > int'(lane_limit)) begin
                    res.status = ST_BAD_LANE;
                end else begin
                    k = nearest_slot(LANE_W'(adj), longint'(r.scan_window), 1'b1);
                    if (k >= 0) begin
                        diff = int'(ego_lat) - int'(slots[k].lat);
                        if (diff < 0)
                            diff = -diff;
                        if (diff > int'(LAT_LIMIT))
                            k = -1;
                    end
                end
            end
            default: ;
        endcase
        if (k >= 0) begin
            res.found = 1'b1;
            res.id    = slots[k].id;
            res.lane  = slots[k].lane;
            res.pos   = slots[k].pos;
            res.lat   = slots[k].lat;
            res.speed = slots[k].speed;
        end
        return res;
    endfunction

    function automatic t_vehicle_request make_request(
        input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
        input logic [LANE_W-1:0] lane, input logic [POS_W-1:0] pos,
        input logic [LAT_W-1:0] lat, input logic [SPD_W-1:0] speed,
        input logic [POS_W-1:0] scan, input logic left);
        t_vehicle_request r;
        r.op            = op;
        r.vehicle_id    = id;
        r.lane          = lane;
        r.position_s    = pos;
        r.lateral_d     = lat;
        r.speed         = speed;
        r.scan_window   = scan;
        r.check_left    = left;
        return r;
    endfunction

    function automatic logic [POS_W-1:0] random_position();
        int idx;
        idx = $urandom_range(TABLE_SLOTS - 1);
        case ($urandom_range(5))
            0: return POS_W'(longint'(ego_pos) + longint'($urandom_range(16384)) - 8192);
            1: return track_len - POS_W'($urandom_range(4095));
            2: return POS_W'($urandom_range(4095));
            3: return slot_used[idx] ? slots[idx].pos : POS_W'($urandom);
            4: return POS_W'($urandom);
            default: return POS_W'($urandom_range(track_len - 1));
        endcase
    endfunction

    function automatic logic [LAT_W-1:0] random_lateral();
        if ($urandom_range(1))
            return LAT_W'(int'(ego_lat) + int'($urandom_range(1400)) - 700);
        return LAT_W'($urandom);
    endfunction

    function automatic logic [POS_W-1:0] random_scan();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        if (pick < 4)
            return POS_W'($urandom_range(16384));
        if (pick < 7)
            return POS_W'($urandom_range(track_len));
        if (pick < 9)
            return POS_W'($urandom);
        return track_len + POS_W'($urandom_range(4095));
    endfunction

    function automatic t_vehicle_request random_request();
        t_vehicle_request r;
        int unsigned      pick;
        int               idx;
        r.vehicle_id    = ($urandom_range(19) == 0) ? ID_W'($urandom)
                                                    : id_pool[$urandom_range(ID_POOL - 1)];
        r.lane          = LANE_W'($urandom);
        r.position_s    = random_position();
        r.lateral_d     = random_lateral();
        r.speed         = SPD_W'($urandom);
        r.scan_window   = random_scan();
        r.check_left    = 1'($urandom);
        pick = $urandom_range(99);
        if (pick < 30)
            r.op = OP_UPD_VEH;
        else if (pick < 40)
            r.op = OP_UPD_EGO;
        else if (pick < 60)
            r.op = OP_AHEAD;
        else if (pick < 80)
            r.op = OP_BEHIND;
        else if (pick < 95)
            r.op = OP_ADJ;
        else
            r.op = OP_W'($urandom_range(OP_LAST, OP_ADJ + 1));
        // aim most lane searches at an occupied lane
        idx = $urandom_range(TABLE_SLOTS - 1);
        if (slot_used[idx] && $urandom_range(9) < 7)
            r.lane = slots[idx].lane;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic issue_request(input t_vehicle_request r);
        while ($urandom_range(99) < tx_idle_pct) begin
            req.valid <= 1'b0;
            @(negedge i_clk);
        end
        req.valid         <= 1'b1;
        req.operation     <= r.op;
        req.vehicle_id    <= r.vehicle_id;
        req.lane          <= r.lane;
        req.position_s    <= r.position_s;
        req.lateral_d     <= r.lateral_d;
        req.speed         <= r.speed;
        req.scan_window   <= r.scan_window;
        req.check_left    <= r.check_left;
        @(posedge i_clk);
        while (!req.ready)
            @(posedge i_clk);
        expected_results.push_back(predict_response(r));
        @(negedge i_clk);
    endtask

    task automatic wait_until_idle();
        req.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TABLE_SLOTS + 8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_settings(input logic [POS_W-1:0] track_units,
                                  input logic [LANE_W-1:0] top_lane);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_TRACK_LEN;
        cfg_data <= CFG_DATA_W'(track_units);
        @(negedge i_clk);
        cfg_idx  <= CFG_MAX_LANE;
        cfg_data <= CFG_DATA_W'(top_lane);
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        track_len  = track_units;
        lane_limit = top_lane;
    endtask

    task automatic test_empty_table();
        issue_request(make_request(OP_AHEAD, 0, 0, 0, 0, 0, 24'hFFFFFF, 0));
        issue_request(make_request(OP_ADJ, 0, 0, 0, 0, 0, 1000, 1));
        issue_request(make_request(OP_ADJ, 0, 0, 0, 0, 0, 1000, 0));
        for (int op = OP_ADJ + 1; op <= OP_LAST; op++)
            issue_request(make_request(OP_W'(op), 8'hFF, 3'h7, 24'hFFFFFF, 12'hFFF,
                                       16'hFFFF, 24'hFFFFFF, 1));
    endtask

    task automatic test_updates_and_ties();
        issue_request(make_request(OP_UPD_VEH, 8'hFF, 3'h7, 24'hFFFFFF, 12'hFFF,
                                   16'hFFFF, 24'hFFFFFF, 1));
        issue_request(make_request(OP_UPD_VEH, 0, 0, 0, 0, 0, 0, 0));
        issue_request(make_request(OP_UPD_EGO, 0, 0, 500, 1200, 0, 0, 0));
        issue_request(make_request(OP_UPD_VEH, 10, 1, 1000, 1100, 3000, 0, 0));
        issue_request(make_request(OP_UPD_VEH, 3, 1, 1000, 1500, 4000, 0, 0));
        // equal positions: lower id wins
        issue_request(make_request(OP_AHEAD, 0, 1, 0, 0, 0, 1000, 0));
        // overwrite in place, now strictly nearer
        issue_request(make_request(OP_UPD_VEH, 10, 1, 900, 1100, 3500, 0, 0));
        issue_request(make_request(OP_AHEAD, 0, 1, 0, 0, 0, 1000, 0));
        issue_request(make_request(OP_BEHIND, 0, 0, 0, 0, 0, 600, 0));
        issue_request(make_request(OP_AHEAD, 0, 1, 0, 0, 0, 0, 0));
    endtask

    task automatic test_wrap_searches();
        issue_request(make_request(OP_UPD_EGO, 0, 0, track_len - POS_W'(100), 1200,
                                   0, 0, 0));
        issue_request(make_request(OP_AHEAD, 0, 0, 0, 0, 0, 200, 0));
        issue_request(make_request(OP_UPD_VEH, 40, 2, track_len - POS_W'(20), 2048,
                                   100, 0, 0));
        issue_request(make_request(OP_UPD_EGO, 0, 0, 50, 1200, 0, 0, 0));
        issue_request(make_request(OP_BEHIND, 0, 2, 0, 0, 0, 200, 0));
    endtask

    task automatic test_adjacent_lanes();
        issue_request(make_request(OP_UPD_EGO, 0, 0, 500, 1200, 0, 0, 0));
        issue_request(make_request(OP_UPD_VEH, 41, 2, 700, 1500, 200, 0, 0));
        issue_request(make_request(OP_UPD_VEH, 42, 0, 800, 0, 300, 0, 0));
        issue_request(make_request(OP_ADJ, 0, 0, 0, 0, 0, 1000, 0));
        // nearest in lane is too far sideways
        issue_request(make_request(OP_ADJ, 0, 0, 0, 0, 0, 1000, 1));
        issue_request(make_request(OP_UPD_EGO, 0, 0, 500, 3000, 0, 0, 0));
        issue_request(make_request(OP_ADJ, 0, 0, 0, 0, 0, 1000, 0));
    endtask

    task automatic test_random_traffic(input int unsigned count);
        repeat (count)
            issue_request(random_request());
    endtask

    always @(negedge i_clk)
        rsp.ready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge i_clk) begin
        t_search_result got;
        t_search_result want;
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("lane_neighbor_search_table test failed");
            $finish;
        end else if (i_rst_n && rsp.valid && rsp.ready) begin
            got = '{rsp.found, rsp.found_id, rsp.found_lane, rsp.found_s, rsp.found_d,
                    rsp.found_speed, rsp.status};
            if (expected_results.size() == 0) begin
                report_mismatch("response with no request outstanding", 1, 0);
            end else begin
                want = expected_results.pop_front();
                if (got.found !== want.found)
                    report_mismatch("found", got.found, want.found);
                if (got.id !== want.id)
                    report_mismatch("found_id", got.id, want.id);
                if (got.lane !== want.lane)
                    report_mismatch("found_lane", got.lane, want.lane);
                if (got.pos !== want.pos)
                    report_mismatch("found_s", got.pos, want.pos);
                if (got.lat !== want.lat)
                    report_mismatch("found_d", got.lat, want.lat);
                if (got.speed !== want.speed)
                    report_mismatch("found_speed", got.speed, want.speed);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
            end
        end
    end

    initial begin
        logic [POS_W-1:0]  track_plan [PHASES];
        logic [LANE_W-1:0] lane_plan [PHASES];
        track_plan = '{TRACK_LEN_RST, 24'd256, 24'hFFFFFF,
                       POS_W'($urandom_range(24'hFFFFFF, 256)), 24'd4096, 24'd65536};
        lane_plan  = '{MAX_LANE_RST, 3'd7, 3'd0, LANE_W'($urandom), 3'd3, 3'd7};
        error_count    = 0;
        stalled_cycles = 0;
        tx_idle_pct    = 7;
        rx_idle_pct    = 57;
        i_rst_n  = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        req.valid         = 1'b0;
        req.operation     = '0;
        req.vehicle_id    = '0;
        req.lane          = '0;
        req.position_s    = '0;
        req.lateral_d     = '0;
        req.speed         = '0;
        req.scan_window   = '0;
        req.check_left    = 1'b0;
        rsp.ready         = 1'b0;
        foreach (slot_used[i])
            slot_used[i] = 1'b0;
        ego_pos    = '0;
        ego_lat    = '0;
        track_len  = TRACK_LEN_RST;
        lane_limit = MAX_LANE_RST;
        id_pool[0] = 8'd0;
        id_pool[1] = 8'hFF;
        id_pool[2] = 8'd3;
        id_pool[3] = 8'd10;
        for (int i = 4; i < ID_POOL; i++)
            id_pool[i] = ID_W'($urandom);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_table();
        test_updates_and_ties();
        test_wrap_searches();
        test_adjacent_lanes();
        wait_until_idle();

        for (int p = 0; p < PHASES; p++) begin
            if (p < 2) begin
                tx_idle_pct = 7;
                rx_idle_pct = 57;
            end else if (p < 4) begin
                tx_idle_pct = 57;
                rx_idle_pct = 7;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_settings(track_plan[p], lane_plan[p]);
            test_random_traffic(288);
            wait_until_idle();
        end

        if (error_count == 0)
            $display("lane_neighbor_search_table test passed");
        else
            $display("lane_neighbor_search_table test failed");
        $finish;
    end

endmodule
